@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty under SYNTH.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/ldp_pkg.sv @@
// ---------------------------------------------------------------------------
// ldp_pkg
// Types, constants and saturating helpers of the lens distortion projection.
// ---------------------------------------------------------------------------
package ldp_pkg;

	localparam int IMAGE_WIDTH  = 1920;
	localparam int IMAGE_HEIGHT = 1080;
	localparam logic signed [31:0] RADIAL_K3 = 32'sd0;

	// Depth threshold, 0.1 m in Q16.16
	localparam logic signed [31:0] DEPTH_MIN = 32'sd6553;

	// Q.28 one and the saturation limit of intermediates
	localparam logic signed [63:0] Q_ONE = 64'sd268435456;
	localparam logic signed [63:0] LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;

	// Restoring divider: one quotient bit per stage over Q16.16 << 28
	localparam int DIV_BITS = 60;
	// Latency from the accept edge to the result register
	localparam int LAT = DIV_BITS + 25;

	localparam logic signed [31:0] IMG_W_Q = 32'(IMAGE_WIDTH * 65536);
	localparam logic signed [31:0] IMG_H_Q = 32'(IMAGE_HEIGHT * 65536);

	typedef enum logic [2:0] {
		CFG_FOCAL_X,
		CFG_FOCAL_Y,
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_RADIAL_K1,
		CFG_RADIAL_K2,
		CFG_TANGENTIAL_P1,
		CFG_TANGENTIAL_P2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_depth;
	} point_t;

	typedef struct packed {
		logic signed [31:0] pixel_u;
		logic signed [31:0] pixel_v;
		logic               projected;
		logic               in_image;
	} pixel_t;

	function automatic logic signed [63:0] clamp(input logic signed [63:0] a);
		logic signed [63:0] r;
		if (a > LIM) begin
			r = LIM;
		end else if (a < -LIM) begin
			r = -LIM;
		end else begin
			r = a;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = clamp(a) + clamp(b);
		return clamp(s);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
		logic signed [31:0] r;
		if (a > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (a < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = a[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		return a[31] ? 32'(~a + 32'd1) : 32'(a);
	endfunction

endpackage

@@ rtl/ldp_mulq.sv @@
// ---------------------------------------------------------------------------
// ldp_mulq
// Three-stage Q.28 multiply: (a*b) >> 28 toward zero, saturated to +-LIM.
// ---------------------------------------------------------------------------
module ldp_mulq (
	input  logic               clk,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] p
);
	import ldp_pkg::*;

	logic        neg_s1, neg_s2;
	logic [61:0] ua_s1, ub_s1;
	logic [63:0] p0_s2, p1_s2, p2_s2;
	logic [59:0] p3_s2;
	logic [123:0] full;
	logic [95:0]  sh;
	logic signed [63:0] mag;

	// Split into sign and magnitude
	always_ff @(posedge clk) begin
		neg_s1 <= a[63] != b[63];
		ua_s1  <= a[63] ? 62'(-a) : 62'(a);
		ub_s1  <= b[63] ? 62'(-b) : 62'(b);
	end

	// Form the four partial products
	always_ff @(posedge clk) begin
		neg_s2 <= neg_s1;
		p0_s2  <= 64'(ua_s1[31:0] * ub_s1[31:0]);
		p1_s2  <= 64'(ua_s1[31:0] * ub_s1[61:32]);
		p2_s2  <= 64'(ua_s1[61:32] * ub_s1[31:0]);
		p3_s2  <= 60'(ua_s1[61:32] * ub_s1[61:32]);
	end

	// Sum, drop the fraction, saturate and restore the sign
	always_comb begin
		full = (124'(p3_s2) << 64) + (124'(p1_s2) << 32) + (124'(p2_s2) << 32)
			+ 124'(p0_s2);
		sh   = full[123:28];
		mag  = (sh > 96'(LIM)) ? LIM : signed'(sh[63:0]);
	end

	always_ff @(posedge clk) begin
		p <= neg_s2 ? -mag : mag;
	end

endmodule

@@ rtl/lens_distortion_projection.sv @@
// ---------------------------------------------------------------------------
// lens_distortion_projection
// Pinhole projection with Brown-Conrady radial and tangential distortion.
// ---------------------------------------------------------------------------
// Takes one camera-frame point per clock (busy stays low) and returns its
// result with one done strobe per point, in order. The pipeline holds the
// 60-stage restoring divider that forms x/z and y/z, followed by six rounds
// of three-stage multipliers and their adders. The receiver cannot stall:
// each result is on pixel for the single cycle in which done is high. Write
// configuration only while no point is in flight; points with depth at or
// below 0.1 m return zero and projected low.
module lens_distortion_projection (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ldp_pkg::point_t point,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	output logic            done,
	output ldp_pkg::pixel_t pixel
);
	import ldp_pkg::*;

	// Configuration registers
	logic [31:0]        focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic signed [31:0] k1_q, k2_q, p1_q, p2_q;

	// Valid and projected flags travel with the data
	logic vld_s  [LAT+1];
	logic proj_s [LAT+1];

	// Divider pipeline, two lanes sharing the divisor
	logic [DIV_BITS-1:0] div_num_s [DIV_BITS+1][2];
	logic [DIV_BITS-1:0] div_quo_s [DIV_BITS+1][2];
	logic [30:0]         div_rem_s [DIV_BITS+1][2];
	logic [30:0]         div_den_s [DIV_BITS+1];
	logic [1:0]          div_neg_s [DIV_BITS+1];

	logic signed [63:0] xn_s, yn_s;
	logic signed [63:0] x2_m, y2_m, xy_m;
	logic signed [63:0] r2_s, tx_s, ty_s, rx_s, ry_s;
	logic signed [63:0] r4_m, k1r2_m, r6_m, k2r4_m, k3r6_m;
	logic signed [63:0] s1_s, s2_s, rad_s;
	logic signed [63:0] xrad_m, yrad_m, p1xy_m, p2xy_m, p2rx_m, p1ry_m;
	logic signed [63:0] ax_s, bx_s, ay_s, by_s, xd_s, yd_s;
	logic signed [63:0] fxxd_m, fyyd_m, u_s, v_s;
	logic signed [31:0] u32, v32;

	logic signed [63:0] xn_d [14];
	logic signed [63:0] yn_d [14];
	logic signed [63:0] r2_d [3];
	logic signed [63:0] s1_d [2];
	logic signed [63:0] s2_d [2];
	logic signed [63:0] xy_d [11];
	logic signed [63:0] rx_d [9];
	logic signed [63:0] ry_d [9];

	// Accept a point in every cycle
	assign busy = 1'b0;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= 32'd65536000;
			focal_y_q  <= 32'd65536000;
			center_x_q <= 32'd62914560;
			center_y_q <= 32'd35389440;
			k1_q       <= '0;
			k2_q       <= '0;
			p1_q       <= '0;
			p2_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FOCAL_X:       focal_x_q  <= cfg_data;
				CFG_FOCAL_Y:       focal_y_q  <= cfg_data;
				CFG_CENTER_X:      center_x_q <= cfg_data;
				CFG_CENTER_Y:      center_y_q <= cfg_data;
				CFG_RADIAL_K1:     k1_q       <= cfg_data;
				CFG_RADIAL_K2:     k2_q       <= cfg_data;
				CFG_TANGENTIAL_P1: p1_q       <= cfg_data;
				CFG_TANGENTIAL_P2: p2_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance valid and projected flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAT; i++) begin
				vld_s[i]  <= 1'b0;
				proj_s[i] <= 1'b0;
			end
		end else begin
			vld_s[0]  <= start && !busy;
			proj_s[0] <= point.point_depth > DEPTH_MIN;
			for (int i = 1; i <= LAT; i++) begin
				vld_s[i]  <= vld_s[i-1];
				proj_s[i] <= proj_s[i-1];
			end
		end
	end

	// Load the divider with |x| << 28 and |y| << 28 over the depth
	always_ff @(posedge clk) begin
		div_num_s[0][0] <= {mag32(point.point_x), 28'd0};
		div_num_s[0][1] <= {mag32(point.point_y), 28'd0};
		div_quo_s[0][0] <= '0;
		div_quo_s[0][1] <= '0;
		div_rem_s[0][0] <= '0;
		div_rem_s[0][1] <= '0;
		div_den_s[0]    <= point.point_depth[30:0];
		div_neg_s[0]    <= {point.point_y[31], point.point_x[31]};
	end

	// One quotient bit per stage
	for (genvar s = 0; s < DIV_BITS; s++) begin : g_div
		always_ff @(posedge clk) begin
			div_den_s[s+1] <= div_den_s[s];
			div_neg_s[s+1] <= div_neg_s[s];
		end
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [31:0] trial;
			logic        fit;
			assign trial = {div_rem_s[s][l], div_num_s[s][l][DIV_BITS-1]};
			assign fit   = trial >= {1'b0, div_den_s[s]};
			always_ff @(posedge clk) begin
				div_rem_s[s+1][l] <= fit ? 31'(trial - {1'b0, div_den_s[s]}) : trial[30:0];
				div_num_s[s+1][l] <= {div_num_s[s][l][DIV_BITS-2:0], 1'b0};
				div_quo_s[s+1][l] <= {div_quo_s[s][l][DIV_BITS-2:0], fit};
			end
		end
	end

	// Restore the sign of the normalized coordinates
	always_ff @(posedge clk) begin
		xn_s <= div_neg_s[DIV_BITS][0] ? -64'(div_quo_s[DIV_BITS][0])
			: 64'(div_quo_s[DIV_BITS][0]);
		yn_s <= div_neg_s[DIV_BITS][1] ? -64'(div_quo_s[DIV_BITS][1])
			: 64'(div_quo_s[DIV_BITS][1]);
	end

	// Squares and cross product
	ldp_mulq u_mul_x2 (.clk(clk), .a(xn_s), .b(xn_s), .p(x2_m));
	ldp_mulq u_mul_y2 (.clk(clk), .a(yn_s), .b(yn_s), .p(y2_m));
	ldp_mulq u_mul_xy (.clk(clk), .a(xn_s), .b(yn_s), .p(xy_m));

	// Radius squared and the tangential sums
	always_ff @(posedge clk) begin
		r2_s <= sadd(x2_m, y2_m);
		tx_s <= sadd(x2_m, x2_m);
		ty_s <= sadd(y2_m, y2_m);
		rx_s <= sadd(r2_s, tx_s);
		ry_s <= sadd(r2_s, ty_s);
	end

	ldp_mulq u_mul_r4   (.clk(clk), .a(r2_s), .b(r2_s), .p(r4_m));
	ldp_mulq u_mul_k1r2 (.clk(clk), .a(64'(k1_q)), .b(r2_s), .p(k1r2_m));
	ldp_mulq u_mul_r6   (.clk(clk), .a(r4_m), .b(r2_d[2]), .p(r6_m));
	ldp_mulq u_mul_k2r4 (.clk(clk), .a(64'(k2_q)), .b(r4_m), .p(k2r4_m));
	ldp_mulq u_mul_k3r6 (.clk(clk), .a(64'(RADIAL_K3)), .b(r6_m), .p(k3r6_m));

	// Accumulate the radial factor
	always_ff @(posedge clk) begin
		s1_s  <= sadd(Q_ONE, k1r2_m);
		s2_s  <= sadd(s1_d[1], k2r4_m);
		rad_s <= sadd(s2_d[1], k3r6_m);
	end

	// Hold operands until their consumers are ready
	always_ff @(posedge clk) begin
		xn_d[0] <= xn_s;
		yn_d[0] <= yn_s;
		for (int i = 1; i < 14; i++) begin
			xn_d[i] <= xn_d[i-1];
			yn_d[i] <= yn_d[i-1];
		end
		r2_d[0] <= r2_s;
		for (int i = 1; i < 3; i++) begin
			r2_d[i] <= r2_d[i-1];
		end
		s1_d[0] <= s1_s;
		s1_d[1] <= s1_d[0];
		s2_d[0] <= s2_s;
		s2_d[1] <= s2_d[0];
		xy_d[0] <= xy_m;
		for (int i = 1; i < 11; i++) begin
			xy_d[i] <= xy_d[i-1];
		end
		rx_d[0] <= rx_s;
		ry_d[0] <= ry_s;
		for (int i = 1; i < 9; i++) begin
			rx_d[i] <= rx_d[i-1];
			ry_d[i] <= ry_d[i-1];
		end
	end

	ldp_mulq u_mul_xrad (.clk(clk), .a(xn_d[13]), .b(rad_s), .p(xrad_m));
	ldp_mulq u_mul_yrad (.clk(clk), .a(yn_d[13]), .b(rad_s), .p(yrad_m));
	ldp_mulq u_mul_p1xy (.clk(clk), .a(64'(p1_q)), .b(xy_d[10]), .p(p1xy_m));
	ldp_mulq u_mul_p2xy (.clk(clk), .a(64'(p2_q)), .b(xy_d[10]), .p(p2xy_m));
	ldp_mulq u_mul_p2rx (.clk(clk), .a(64'(p2_q)), .b(rx_d[8]), .p(p2rx_m));
	ldp_mulq u_mul_p1ry (.clk(clk), .a(64'(p1_q)), .b(ry_d[8]), .p(p1ry_m));

	// Combine radial and tangential terms
	always_ff @(posedge clk) begin
		ax_s <= sadd(xrad_m, sadd(p1xy_m, p1xy_m));
		bx_s <= p2rx_m;
		ay_s <= sadd(yrad_m, p1ry_m);
		by_s <= sadd(p2xy_m, p2xy_m);
		xd_s <= sadd(ax_s, bx_s);
		yd_s <= sadd(ay_s, by_s);
	end

	ldp_mulq u_mul_fx (.clk(clk), .a(signed'(64'(focal_x_q))), .b(xd_s), .p(fxxd_m));
	ldp_mulq u_mul_fy (.clk(clk), .a(signed'(64'(focal_y_q))), .b(yd_s), .p(fyyd_m));

	// Offset by the principal point
	always_ff @(posedge clk) begin
		u_s <= sadd(fxxd_m, signed'(64'(center_x_q)));
		v_s <= sadd(fyyd_m, signed'(64'(center_y_q)));
	end

	assign u32 = sat32(u_s);
	assign v32 = sat32(v_s);

	// Register the result; drop coordinates of points too close
	always_ff @(posedge clk) begin
		if (proj_s[LAT-1]) begin
			pixel.pixel_u   <= u32;
			pixel.pixel_v   <= v32;
			pixel.projected <= 1'b1;
			pixel.in_image  <= (u32 >= 0) && (v32 >= 0) && (u32 < IMG_W_Q) && (v32 < IMG_H_Q);
		end else begin
			pixel <= '0;
		end
	end

	assign done = vld_s[LAT];

	`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_in_image_projected, clk, arst_n, done && pixel.in_image, pixel.projected)
	`ASSERT_IMPLIES(a_unprojected_zero, clk, arst_n, done && !pixel.projected, pixel.pixel_u == 0 && pixel.pixel_v == 0 && !pixel.in_image)
	`ASSERT_IMPLIES(a_done_from_start, clk, arst_n, done, $past(start, LAT + 1))
	`ASSERT_NEXT(a_start_enters, clk, arst_n, start && !busy, vld_s[0] && !done == !vld_s[LAT])

endmodule

@@ test/ldp_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ldp_checker
// Watches the point, pixel and configuration channels of the projection
// block, predicts each pixel from its own copy of the registers and compares.
// ----------------------------------------------------------------------------
module ldp_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  ldp_pkg::point_t point,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic            done,
	input  ldp_pkg::pixel_t pixel,
	output int              pending,
	output int              errors
);
	import ldp_pkg::*;

	localparam logic signed [63:0] SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;
	// Room for every transaction in flight, with margin
	localparam int EXP_DEPTH = 256;

	logic [31:0] lens_regs [8];
	pixel_t      expect_mem [EXP_DEPTH];
	int          wr_count;
	int          rd_count;

	// Bound an intermediate to the Q.28 range
	function automatic logic signed [63:0] bound_q28(input logic signed [63:0] a);
		logic signed [63:0] r;
		r = a;
		if (a > SAT_LIM) r = SAT_LIM;
		if (a < -SAT_LIM) r = -SAT_LIM;
		return r;
	endfunction

	function automatic logic signed [63:0] add_q28(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return bound_q28(bound_q28(a) + bound_q28(b));
	endfunction

	// Exact product, shifted by 28 toward zero, then saturated
	function automatic logic signed [63:0] mul_q28(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [63:0]        ua;
		logic [63:0]        ub;
		logic [127:0]       prod;
		logic signed [63:0] m;
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		prod = ({64'd0, ua} * {64'd0, ub}) >> 28;
		if (prod > {64'd0, SAT_LIM}) m = SAT_LIM;
		else m = prod[63:0];
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic logic signed [31:0] clip32(input logic signed [63:0] a);
		logic signed [31:0] r;
		if (a > 64'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (a < -64'sd2147483648) r = 32'sh8000_0000;
		else r = a[31:0];
		return r;
	endfunction

	function automatic pixel_t project_point(input point_t p);
		pixel_t             r;
		logic signed [63:0] px, py, pz, k1, k2, k3, p1, p2, fx, fy, cx, cy;
		logic signed [63:0] xn, yn, x2, y2, xy, r2, r4, r6, rad, xd, yd, u, v;
		r = '0;
		px = 64'(p.point_x);
		py = 64'(p.point_y);
		pz = 64'(p.point_depth);
		if (pz > 64'(DEPTH_MIN)) begin
			k1 = 64'($signed(lens_regs[CFG_RADIAL_K1]));
			k2 = 64'($signed(lens_regs[CFG_RADIAL_K2]));
			k3 = 64'(RADIAL_K3);
			p1 = 64'($signed(lens_regs[CFG_TANGENTIAL_P1]));
			p2 = 64'($signed(lens_regs[CFG_TANGENTIAL_P2]));
			fx = $signed({32'd0, lens_regs[CFG_FOCAL_X]});
			fy = $signed({32'd0, lens_regs[CFG_FOCAL_Y]});
			cx = $signed({32'd0, lens_regs[CFG_CENTER_X]});
			cy = $signed({32'd0, lens_regs[CFG_CENTER_Y]});
			xn = (px * ONE_Q28) / pz;
			yn = (py * ONE_Q28) / pz;
			x2 = mul_q28(xn, xn);
			y2 = mul_q28(yn, yn);
			xy = mul_q28(xn, yn);
			r2 = add_q28(x2, y2);
			r4 = mul_q28(r2, r2);
			r6 = mul_q28(r4, r2);
			rad = add_q28(add_q28(add_q28(ONE_Q28, mul_q28(k1, r2)), mul_q28(k2, r4)),
				mul_q28(k3, r6));
			xd = mul_q28(xn, rad);
			xd = add_q28(xd, add_q28(mul_q28(p1, xy), mul_q28(p1, xy)));
			xd = add_q28(xd, mul_q28(p2, add_q28(r2, add_q28(x2, x2))));
			yd = mul_q28(yn, rad);
			yd = add_q28(yd, mul_q28(p1, add_q28(r2, add_q28(y2, y2))));
			yd = add_q28(yd, add_q28(mul_q28(p2, xy), mul_q28(p2, xy)));
			u = 64'(clip32(add_q28(mul_q28(fx, xd), cx)));
			v = 64'(clip32(add_q28(mul_q28(fy, yd), cy)));
			r.pixel_u = u[31:0];
			r.pixel_v = v[31:0];
			r.projected = 1'b1;
			r.in_image = (u >= 0) && (v >= 0) && (u < 64'(IMAGE_WIDTH) * 65536)
				&& (v < 64'(IMAGE_HEIGHT) * 65536);
		end
		return r;
	endfunction

	assign pending = wr_count - rd_count;

	// Predict on each accepted transaction, compare each strobed pixel
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			lens_regs[CFG_FOCAL_X]       <= 32'd65536000;
			lens_regs[CFG_FOCAL_Y]       <= 32'd65536000;
			lens_regs[CFG_CENTER_X]      <= 32'd62914560;
			lens_regs[CFG_CENTER_Y]      <= 32'd35389440;
			lens_regs[CFG_RADIAL_K1]     <= 32'd0;
			lens_regs[CFG_RADIAL_K2]     <= 32'd0;
			lens_regs[CFG_TANGENTIAL_P1] <= 32'd0;
			lens_regs[CFG_TANGENTIAL_P2] <= 32'd0;
			wr_count = 0;
			rd_count = 0;
			errors <= 0;
		end else begin
			if (done) begin
				if (wr_count == rd_count) begin
					$display("%0t: unexpected pixel %h", $time, pixel);
					errors <= errors + 1;
				end else begin
					want = expect_mem[rd_count % EXP_DEPTH];
					rd_count = rd_count + 1;
					if (want !== pixel) begin
						$display("%0t: pixel mismatch: expected u=%h v=%h p=%b i=%b, got u=%h v=%h p=%b i=%b",
							$time, want.pixel_u, want.pixel_v, want.projected, want.in_image,
							pixel.pixel_u, pixel.pixel_v, pixel.projected, pixel.in_image);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy) begin
				expect_mem[wr_count % EXP_DEPTH] = project_point(point);
				wr_count = wr_count + 1;
			end
			if (cfg_we) lens_regs[cfg_index] <= cfg_data;
		end
	end
endmodule

@@ test/lens_distortion_projection_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lens_distortion_projection_tb
// Drives directed and random points through several lens settings, with
// random start gaps; the checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module lens_distortion_projection_tb;
	import ldp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	point_t      point = '0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        done;
	pixel_t      pixel;
	int          pending;
	int          errors;
	bit          gaps_on = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lens_distortion_projection i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .pixel(pixel)
	);

	ldp_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .pixel(pixel), .pending(pending), .errors(errors)
	);

	// Offer one point, idling at random first; hold until accepted
	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		while (gaps_on && $urandom_range(99) < 23) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		point <= '{point_x: x, point_y: y, point_depth: z};
		@(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drain all pixels in flight before touching the registers
	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LAT + 5) @(negedge clk);
	endtask

	task automatic random_point();
		logic [31:0] x, y, z;
		int          mode;
		mode = $urandom_range(9);
		x = $urandom;
		y = $urandom;
		z = $urandom;
		if (mode == 1) begin
			z = 32'd6553 + $urandom_range(2) - 1;
		end else if (mode >= 2) begin
			x = 32'($signed($urandom_range(2097152)) - 1048576);
			y = 32'($signed($urandom_range(2097152)) - 1048576);
			z = $urandom_range(4194304, 6554);
		end
		send_point(x, y, z);
	endtask

	task automatic random_lens(input bit wild);
		write_reg(CFG_FOCAL_X, wild ? $urandom : $urandom_range(200000000, 10000000));
		write_reg(CFG_FOCAL_Y, wild ? $urandom : $urandom_range(200000000, 10000000));
		write_reg(CFG_CENTER_X, wild ? $urandom : $urandom_range(125829120));
		write_reg(CFG_CENTER_Y, wild ? $urandom : $urandom_range(70778880));
		write_reg(CFG_RADIAL_K1, wild ? $urandom : 32'($signed($urandom_range(200000000)) - 100000000));
		write_reg(CFG_RADIAL_K2, wild ? $urandom : 32'($signed($urandom_range(40000000)) - 20000000));
		write_reg(CFG_TANGENTIAL_P1, wild ? $urandom : 32'($signed($urandom_range(4000000)) - 2000000));
		write_reg(CFG_TANGENTIAL_P2, wild ? $urandom : 32'($signed($urandom_range(4000000)) - 2000000));
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed points at reset settings
		send_point(32'd0, 32'd0, 32'd65536);
		send_point(32'd65536, 32'd32768, 32'd6553);
		send_point(32'd65536, 32'd32768, 32'd6554);
		send_point(32'd65536, 32'd65536, 32'd0);
		send_point(32'd65536, 32'd65536, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd6554);
		send_point(32'h8000_0000, 32'h8000_0000, 32'd6554);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'hFFFF_0000, 32'hFFFF_8000, 32'd131072);
		send_point(32'd1000, 32'd1000, 32'd65536);
		drain();

		// Extreme lens: full focal, zero center x, full center y, largest coefficients
		write_reg(CFG_FOCAL_X, 32'hFFFF_FFFF);
		write_reg(CFG_FOCAL_Y, 32'hFFFF_FFFF);
		write_reg(CFG_CENTER_X, 32'd0);
		write_reg(CFG_CENTER_Y, 32'hFFFF_FFFF);
		write_reg(CFG_RADIAL_K1, 32'h7FFF_FFFF);
		write_reg(CFG_RADIAL_K2, 32'h8000_0000);
		write_reg(CFG_TANGENTIAL_P1, 32'h7FFF_FFFF);
		write_reg(CFG_TANGENTIAL_P2, 32'h8000_0000);
		send_point(32'd65536, 32'd65536, 32'd65536);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd6554);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd6554);
		send_point(32'd100, 32'hFFFF_FF00, 32'd1000000);
		drain();
		write_reg(CFG_FOCAL_X, 32'd0);
		write_reg(CFG_FOCAL_Y, 32'd0);
		write_reg(CFG_RADIAL_K1, 32'h8000_0000);
		write_reg(CFG_TANGENTIAL_P1, 32'h8000_0000);
		write_reg(CFG_TANGENTIAL_P2, 32'h7FFF_FFFF);
		send_point(32'd65536, 32'd65536, 32'd65536);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd6554);
		for (int i = 0; i < 60; i++) random_point();
		drain();

		// Random phases with plausible and wild lenses
		for (int phase = 0; phase < 5; phase++) begin
			random_lens(phase == 3);
			for (int i = 0; i < 100; i++) begin
				gaps_on = !(phase == 2 && i < 60);
				random_point();
			end
			gaps_on = 1'b1;
			drain();
		end

		if (errors == 0) begin
			$display("lens_distortion_projection_tb: clean");
		end else begin
			$display("lens_distortion_projection_tb: errors");
		end
		$finish;
	end

	// Bound the run
	initial begin
		#2000000;
		$display("lens_distortion_projection_tb: errors");
		$finish;
	end
endmodule
